FILE: sv/char_class_tokenizer_core_defines.svh
// Assertion macros used by the tokenizer front end.
`ifndef CHAR_CLASS_TOKENIZER_CORE_DEFINES_SVH
`define CHAR_CLASS_TOKENIZER_CORE_DEFINES_SVH

// Same-cycle implication, checked after reset is released.
`define CCTOK_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked after reset is released.
`define CCTOK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/cctok_pkg.sv
// Types and constants for the character class tokenizer.
`default_nettype none
package cctok_pkg;

  localparam int MAX_HELD   = 15;
  localparam int HELD_CNT_W = $clog2(MAX_HELD + 1);
  localparam int HELD_IDX_W = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;

  localparam int CHAR_W    = 8;
  localparam int NUM_CODES = 128;
  localparam int CODE_W    = $clog2(NUM_CODES);
  localparam int SET_W     = 64;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VALID_LO = 3'd0,
    REG_VALID_HI = 3'd1,
    REG_START_LO = 3'd2,
    REG_START_HI = 3'd3,
    REG_END_LO   = 3'd4,
    REG_END_HI   = 3'd5,
    REG_SINGLE   = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_CHAR     = 2'd0,
    KIND_END      = 2'd1,
    KIND_EMPTY    = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_t;

  typedef struct packed {
    logic [CHAR_W-1:0] in_char;
    logic              end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic [1:0]        out_kind;
    logic              last;
  } out_item_t;

  // One command per accepted item: flush held chars, then the char, then
  // up to two markers. hold appends the char to the back's held buffer.
  typedef struct packed {
    logic [CHAR_W-1:0]     ch;
    logic                  hold;
    logic [HELD_IDX_W-1:0] hold_idx;
    logic [HELD_CNT_W-1:0] nflush;
    logic                  do_char;
    logic                  m1_en;
    kind_t                 m1_kind;
    logic                  m2_en;
    kind_t                 m2_kind;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

endpackage
`default_nettype wire

FILE: sv/cctok_front.sv
// Front end: config registers, class lookup, token state, command build.
`default_nettype none
`include "char_class_tokenizer_core_defines.svh"
module cctok_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [cctok_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [cctok_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                              accept,
  input  wire cctok_pkg::in_item_t               item,
  output cctok_pkg::cmd_t                        cmd
);

  logic [cctok_pkg::NUM_CODES-1:0] valid_set, start_set, end_set;
  logic                            single_mode;

  logic                              in_token, in_token_next;
  logic                              emitted_any, emitted_any_next;
  logic                              skip_rest, skip_rest_next;
  logic [cctok_pkg::HELD_CNT_W-1:0]  held_count, held_count_next;

  logic [cctok_pkg::CODE_W-1:0] code;
  logic                         is_v, is_s, is_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_set   <= '0;
      start_set   <= '0;
      end_set     <= '0;
      single_mode <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        cctok_pkg::REG_VALID_LO: valid_set[cctok_pkg::SET_W-1:0] <= cfg_data;
        cctok_pkg::REG_VALID_HI: valid_set[cctok_pkg::NUM_CODES-1:cctok_pkg::SET_W] <= cfg_data;
        cctok_pkg::REG_START_LO: start_set[cctok_pkg::SET_W-1:0] <= cfg_data;
        cctok_pkg::REG_START_HI: start_set[cctok_pkg::NUM_CODES-1:cctok_pkg::SET_W] <= cfg_data;
        cctok_pkg::REG_END_LO:   end_set[cctok_pkg::SET_W-1:0] <= cfg_data;
        cctok_pkg::REG_END_HI:   end_set[cctok_pkg::NUM_CODES-1:cctok_pkg::SET_W] <= cfg_data;
        cctok_pkg::REG_SINGLE:   single_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // codes 128 and up belong to no class
  assign code = item.in_char[cctok_pkg::CODE_W-1:0];
  assign is_v = !item.in_char[cctok_pkg::CHAR_W-1] && valid_set[code];
  assign is_s = !item.in_char[cctok_pkg::CHAR_W-1] && start_set[code];
  assign is_e = !item.in_char[cctok_pkg::CHAR_W-1] && end_set[code];

  always_comb begin
    in_token_next    = in_token;
    emitted_any_next = emitted_any;
    skip_rest_next   = skip_rest;
    held_count_next  = held_count;

    cmd          = '0;
    cmd.ch       = item.in_char;
    cmd.m1_kind  = cctok_pkg::KIND_END;
    cmd.m2_kind  = cctok_pkg::KIND_END;

    if (single_mode) begin
      cmd.do_char = 1'b1;
      cmd.m1_en   = 1'b1;
    end else begin
      if (skip_rest) begin
        if (!is_v) begin
          skip_rest_next = 1'b0;
        end
      end else if (!in_token) begin
        if (is_s && is_v) begin
          in_token_next    = 1'b1;
          emitted_any_next = 1'b0;
          held_count_next  = '0;
        end
      end else if (!is_v) begin
        cmd.m1_en        = 1'b1;
        cmd.m1_kind      = emitted_any ? cctok_pkg::KIND_END : cctok_pkg::KIND_EMPTY;
        in_token_next    = 1'b0;
        emitted_any_next = 1'b0;
        held_count_next  = '0;
      end

      if (in_token_next && is_v) begin
        if (is_e) begin
          cmd.nflush       = held_count_next;
          cmd.do_char      = 1'b1;
          held_count_next  = '0;
          emitted_any_next = 1'b1;
        end else if (held_count_next >= cctok_pkg::HELD_CNT_W'(cctok_pkg::MAX_HELD)) begin
          cmd.m1_en        = 1'b1;
          cmd.m1_kind      = cctok_pkg::KIND_OVERFLOW;
          in_token_next    = 1'b0;
          emitted_any_next = 1'b0;
          held_count_next  = '0;
          skip_rest_next   = 1'b1;
        end else begin
          cmd.hold        = 1'b1;
          cmd.hold_idx    = held_count_next[cctok_pkg::HELD_IDX_W-1:0];
          held_count_next = held_count_next + 1'b1;
        end
      end
    end

    if (item.end_of_text) begin
      if (in_token_next) begin
        // close marker lands after whatever marker this item already has
        if (cmd.m1_en) begin
          cmd.m2_en   = 1'b1;
          cmd.m2_kind = emitted_any_next ? cctok_pkg::KIND_END : cctok_pkg::KIND_EMPTY;
        end else begin
          cmd.m1_en   = 1'b1;
          cmd.m1_kind = emitted_any_next ? cctok_pkg::KIND_END : cctok_pkg::KIND_EMPTY;
        end
      end
      in_token_next    = 1'b0;
      emitted_any_next = 1'b0;
      held_count_next  = '0;
      skip_rest_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_token    <= 1'b0;
      emitted_any <= 1'b0;
      skip_rest   <= 1'b0;
      held_count  <= '0;
    end else if (accept) begin
      in_token    <= in_token_next;
      emitted_any <= emitted_any_next;
      skip_rest   <= skip_rest_next;
      held_count  <= held_count_next;
    end
  end

  `CCTOK_ASSERT_NOW(a_idle_clean, !in_token,
    held_count == '0 && !emitted_any, "held chars or emitted flag outside a token")
  `CCTOK_ASSERT_NOW(a_skip_no_token, skip_rest, !in_token,
    "skipping while a token is open")
  `CCTOK_ASSERT_NOW(a_held_bound, 1'b1,
    held_count <= cctok_pkg::HELD_CNT_W'(cctok_pkg::MAX_HELD), "held count past buffer size")
  `CCTOK_ASSERT_NOW(a_hold_alone, accept && cmd.hold,
    cmd.nflush == '0 && !cmd.do_char && !cmd.m2_en, "hold command also emits chars")

endmodule
`default_nettype wire

FILE: sv/cctok_queue.sv
// Small command queue between front and back ends.
`default_nettype none
module cctok_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire cctok_pkg::cmd_t       push_cmd,
  input  wire logic                  pop,
  output cctok_pkg::cmd_t            head,
  output cctok_pkg::queue_stat_t     stat
);

  cctok_pkg::cmd_t                    mem [cctok_pkg::QUEUE_DEPTH];
  logic [cctok_pkg::QUEUE_PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [cctok_pkg::QUEUE_CNT_W-1:0]  count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

  assign head       = mem[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == cctok_pkg::QUEUE_CNT_W'(cctok_pkg::QUEUE_DEPTH));

endmodule
`default_nettype wire

FILE: sv/cctok_back.sv
// Back end: held char buffer, result sequencer and output register.
`default_nettype none
module cctok_back (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire cctok_pkg::cmd_t         head,
  input  wire cctok_pkg::queue_stat_t  qstat,
  output logic                         pop,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output cctok_pkg::out_item_t         out_item
);

  logic [cctok_pkg::CHAR_W-1:0] held [cctok_pkg::MAX_HELD];

  cctok_pkg::cmd_t                   cur;
  logic                              busy;
  logic [cctok_pkg::HELD_CNT_W-1:0]  fidx;

  logic                              emit, rest, in_flush, head_has_results;
  cctok_pkg::out_item_t              res;

  assign emit     = busy && (!out_valid || !out_stall);
  assign in_flush = (fidx < cur.nflush);

  always_comb begin
    res          = '0;
    rest         = 1'b0;
    if (in_flush) begin
      res.out_char = held[fidx[cctok_pkg::HELD_IDX_W-1:0]];
      res.out_kind = cctok_pkg::KIND_CHAR;
      rest         = (fidx + 1'b1 < cur.nflush) || cur.do_char || cur.m1_en || cur.m2_en;
    end else if (cur.do_char) begin
      res.out_char = cur.ch;
      res.out_kind = cctok_pkg::KIND_CHAR;
      rest         = cur.m1_en || cur.m2_en;
    end else if (cur.m1_en) begin
      res.out_kind = cur.m1_kind;
      rest         = cur.m2_en;
    end else begin
      res.out_kind = cur.m2_kind;
    end
    res.last = !rest;
  end

  assign head_has_results = (head.nflush != '0) || head.do_char || head.m1_en || head.m2_en;
  assign pop = !qstat.empty && (!busy || (emit && !rest));

  always_ff @(posedge clk) begin
    if (pop && head.hold) begin
      held[head.hold_idx] <= head.ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fidx <= '0;
    end else if (pop) begin
      cur  <= head;
      busy <= head_has_results;
      fidx <= '0;
    end else if (emit) begin
      if (!rest) begin
        busy <= 1'b0;
      end
      if (in_flush) begin
        fidx <= fidx + 1'b1;
      end else if (cur.do_char) begin
        cur.do_char <= 1'b0;
      end else if (cur.m1_en) begin
        cur.m1_en <= 1'b0;
      end else begin
        cur.m2_en <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item <= res;
    end
  end

endmodule
`default_nettype wire

FILE: sv/char_class_tokenizer_core.sv
// Top level of the character class tokenizer.
//
//   port group       dir  handshake              payload
//   in_*             in   in_valid / in_stall    in_item  (in_char, end_of_text)
//   out_*            out  out_valid / out_stall  out_item (out_char, out_kind, last)
//   cfg_*            in   cfg_write              cfg_index, cfg_data
//
// The front end takes one item per cycle into a four-entry command queue
// while the queue is not full. The back end sends one result per cycle
// unless out_stall holds it; the single output port sets this rate.
// in_stall rises only when the queue is full; out_stall holds the output.
// Reset is synchronous: clears token state, queue, output and config.
`default_nettype none
module char_class_tokenizer_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire cctok_pkg::in_item_t               in_item,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output cctok_pkg::out_item_t                   out_item,
  input  wire logic                              cfg_write,
  input  wire logic [cctok_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [cctok_pkg::CFG_DATA_W-1:0]  cfg_data
);

  cctok_pkg::cmd_t         front_cmd, head;
  cctok_pkg::queue_stat_t  qstat;
  logic                    accept, pop;

  assign in_stall = qstat.full;
  assign accept   = in_valid && !qstat.full;

  cctok_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .item      (in_item),
    .cmd       (front_cmd)
  );

  cctok_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_cmd (front_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (qstat)
  );

  cctok_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire
